@@ src/tphm_pkg.sv @@
// Package for the thermocouple peak-hold monitor: item and result types,
// timing constants, request codes and the raw-to-degrees conversion.
// No dependencies.
package tphm_pkg;

    localparam logic [6:0] PEAK_HOLD_TICKS = 7'd100;
    localparam logic [5:0] BLINK_TICKS     = 6'd32;
    localparam logic [12:0] TC_OFFSET      = 13'd5;

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_DISPLAY = 1'b1;

    // Register map, indexed by paddr[2]
    localparam logic REG_UNITS = 1'b0;

    typedef logic signed [11:0] t_temp;

    typedef struct packed {
        logic       req_type;
        logic [7:0] read_status;
        logic [7:0] cold_junction_msb;
        logic [7:0] volts_msb;
        logic [7:0] volts_lsb;
        logic       peak_mode;
    } t_item;

    typedef struct packed {
        logic  result_kind;
        t_temp temperature;
        logic  peak_hold;
        logic  show_error;
        logic  fahrenheit;
        logic  led_write;
        logic  led_on;
    } t_result;

    // Linear fit: 5 + (3 * raw) >> 3, zero when the reading is negative,
    // plus the signed cold-junction byte.
    function automatic t_temp tphm_convert(input logic [7:0] cj,
                                           input logic [7:0] vmsb,
                                           input logic [4:0] vlow);
        logic [11:0] raw;
        logic [13:0] prod;
        logic [12:0] base;
        logic [12:0] sum;
        raw  = {vmsb[6:0], vlow};
        prod = {2'b00, raw} + {1'b0, raw, 1'b0};
        if (vmsb[7]) begin
            base = 13'd0;
        end else begin
            base = {2'b00, prod[13:3]} + TC_OFFSET;
        end
        sum = base + {{5{cj[7]}}, cj};
        return t_temp'(sum[11:0]);
    endfunction

endpackage

@@ src/thermocouple_peak_hold_monitor.sv @@
// Thermocouple peak-hold monitor, top level: input register, core, result register, APB.
// An accepted request waits in the input register until the result register is free.
// Throughput: one request per cycle; the input stage advances whenever the result
// register is empty or being taken in the same cycle.
// Reset (synchronous, active low) clears stored reading, peak, age, blink count,
// the units register and both stage valid flags.
module thermocouple_peak_hold_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [7:0]         i_read_status,
    input  logic [7:0]         i_cold_junction_msb,
    input  logic [7:0]         i_volts_msb,
    input  logic [7:0]         i_volts_lsb,
    input  logic               i_peak_mode,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_result_kind,
    output logic signed [11:0] o_temperature,
    output logic               o_peak_hold,
    output logic               o_show_error,
    output logic               o_fahrenheit,
    output logic               o_led_write,
    output logic               o_led_on,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tphm_pkg::*;

    logic    r_units;
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;
    logic    w_out_free;
    logic    w_fire;
    logic    w_accept;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_UNITS) ? {31'd0, r_units} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_units <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == REG_UNITS) begin
            r_units <= pwdata[0];
        end
    end

    // handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.req_type          <= i_req_type;
            r_item.read_status       <= i_read_status;
            r_item.cold_junction_msb <= i_cold_junction_msb;
            r_item.volts_msb         <= i_volts_msb;
            r_item.volts_lsb         <= i_volts_lsb;
            r_item.peak_mode         <= i_peak_mode;
        end
    end

    tphm_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_units_f (r_units),
        .i_item    (r_item),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.result_kind;
    assign o_temperature = r_out.temperature;
    assign o_peak_hold   = r_out.peak_hold;
    assign o_show_error  = r_out.show_error;
    assign o_fahrenheit  = r_out.fahrenheit;
    assign o_led_write   = r_out.led_write;
    assign o_led_on      = r_out.led_on;

`ifndef SYNTHESIS
    a_tick_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == REQ_TICK) |->
            (o_temperature == 12'sd0 && !o_peak_hold && !o_show_error))
        else $error("tick result carries display fields");
    a_disp_no_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == REQ_DISPLAY) |-> !o_led_write)
        else $error("display result issues an LED write");
    a_led_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_led_on) |-> o_led_write)
        else $error("LED on without LED write");
    a_err_xor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_show_error && o_peak_hold))
        else $error("error and held peak shown together");
`endif

endmodule

@@ src/tphm_core.sv @@
// Monitor state and per-request update: stored reading, peak hold, peak age,
// blink window. Produces the result for the request held in the input stage.
// Depends on tphm_pkg.
module tphm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_units_f,
    input  tphm_pkg::t_item   i_item,
    output tphm_pkg::t_result o_result
);
    import tphm_pkg::*;

    logic [7:0] r_status, n_status;
    logic [7:0] r_cj, n_cj;
    logic [7:0] r_vmsb, n_vmsb;
    logic [4:0] r_vlow, n_vlow;
    t_temp      r_peak, n_peak;
    logic [6:0] r_age, n_age;
    logic [5:0] r_blink, n_blink;
    t_temp      w_conv;

    assign w_conv = tphm_convert(r_cj, r_vmsb, r_vlow);

    always_comb begin
        t_temp t;
        n_status = r_status;
        n_cj     = r_cj;
        n_vmsb   = r_vmsb;
        n_vlow   = r_vlow;
        n_peak   = r_peak;
        n_age    = r_age;
        n_blink  = r_blink;
        t        = '0;
        o_result = '0;
        o_result.result_kind = i_item.req_type;
        o_result.fahrenheit  = i_units_f;
        if (i_item.req_type == REQ_TICK) begin
            n_status = i_item.read_status;
            n_cj     = i_item.cold_junction_msb;
            n_vmsb   = i_item.volts_msb;
            n_vlow   = i_item.volts_lsb[7:3];
            if (r_age < PEAK_HOLD_TICKS) begin
                n_age = r_age + 7'd1;
            end
            if (r_blink < BLINK_TICKS) begin
                n_blink            = r_blink + 6'd1;
                o_result.led_write = 1'b1;
                o_result.led_on    = (n_blink[1:0] == 2'b00);
            end
        end else begin
            if (r_status == 8'd0) begin
                t = w_conv;
                if (i_item.peak_mode) begin
                    if (t > r_peak) begin
                        n_peak = t;
                        n_age  = 7'd0;
                    end
                    if (n_age < PEAK_HOLD_TICKS) begin
                        o_result.peak_hold = 1'b1;
                        t = n_peak;
                    end
                end
            end else begin
                t = t_temp'({4'b0000, r_status});
                o_result.show_error = 1'b1;
            end
            // negative reading or read error reopens a closed blink window
            if ((r_vmsb[7] || r_status != 8'd0) && r_blink >= BLINK_TICKS) begin
                n_blink = 6'd0;
            end
            o_result.temperature = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            r_cj     <= '0;
            r_vmsb   <= '0;
            r_vlow   <= '0;
            r_peak   <= '0;
            r_age    <= '0;
            r_blink  <= '0;
        end else if (i_fire) begin
            r_status <= n_status;
            r_cj     <= n_cj;
            r_vmsb   <= n_vmsb;
            r_vlow   <= n_vlow;
            r_peak   <= n_peak;
            r_age    <= n_age;
            r_blink  <= n_blink;
        end
    end

`ifndef SYNTHESIS
    a_age_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_age <= PEAK_HOLD_TICKS)
        else $error("peak age beyond hold time");
    a_blink_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink <= BLINK_TICKS)
        else $error("blink count beyond window");
    a_peak_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_peak[11])
        else $error("held peak went negative");
`endif

endmodule
